FILE: rtl/core/mts_pkg.sv
`default_nettype none

package mts_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 11;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/max_tracking_stack_core.sv
`default_nettype none

// LIFO stack of signed 32-bit values that reports the largest value it holds
// after every action. Each entry stores, in a synchronous RAM with a registered
// read, the running maximum of itself and every entry below it; the running
// maximum of the top entry is kept in a register. A push, a query, any refused
// action and a pop that empties the stack complete in the accept state. A pop
// that leaves entries behind then enters the read state: the new top's running
// maximum is read back from the RAM, and the input is stalled during that read.
// The RAM needs no clearing after reset, since only entries below the fill
// count are ever read. One result is produced for every input transfer. A new
// input is taken only in a cycle in which the output register is empty or its
// result leaves, so a stalled result holds the input stalled as well.
module max_tracking_stack_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mts_pkg::ACTION_W-1:0]   action,
    input  wire logic signed [mts_pkg::DATA_W-1:0] value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mts_pkg::STATUS_W-1:0]        status,
    output logic signed [mts_pkg::DATA_W-1:0]   max_value,
    output logic                                is_empty,
    output logic [mts_pkg::FILL_W-1:0]          fill_count
);
    import mts_pkg::*;

    typedef enum logic {S_ACCEPT, S_READ} state_t;

    state_t                    state_reg, state_next;
    logic [PTR_W-1:0]          sp_reg, sp_next;
    logic signed [DATA_W-1:0]  top_reg, top_next;
    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [DATA_W-1:0]  max_reg, max_next;
    logic                      empty_reg, empty_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;

    logic signed [DATA_W-1:0]  run_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0]  rd_data_reg;
    logic                      wr_en;
    logic                      rd_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0]  wr_data;

    logic                      in_xfer;
    logic                      out_xfer;
    logic                      full;
    logic [PTR_W-1:0]          sp_minus2;
    logic [PTR_W-1:0]          sp_plus1;
    logic [PTR_W-1:0]          sp_minus1;
    logic signed [DATA_W-1:0]  push_run;

    // Handshake
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg == S_READ) || (out_valid_reg && out_stall);
    assign in_xfer  = in_valid && !in_stall;

    assign full      = (sp_reg == PTR_W'(STACK_DEPTH));
    assign sp_plus1  = sp_reg + PTR_W'(1);
    assign sp_minus1 = sp_reg - PTR_W'(1);
    assign sp_minus2 = sp_reg - PTR_W'(2);

    // Running maximum for a new entry
    assign push_run = ((sp_reg != '0) && (top_reg > value)) ? top_reg : value;

    // Next-state and result logic
    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        status_next    = status_reg;
        max_next       = max_reg;
        empty_next     = empty_reg;
        fill_next      = fill_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = sp_reg[ADDR_W-1:0];
        rd_addr        = sp_minus2[ADDR_W-1:0];
        wr_data        = push_run;

        if (state_reg == S_READ)
        begin
            // Finish a pop: the new top comes back from the RAM
            top_next       = rd_data_reg;
            out_valid_next = 1'b1;
            status_next    = STS_OK;
            max_next       = rd_data_reg;
            empty_next     = 1'b0;
            fill_next      = FILL_W'(sp_reg);
            state_next     = S_ACCEPT;
        end
        else if (in_xfer)
        begin
            out_valid_next = 1'b1;
            status_next    = STS_OK;
            max_next       = (sp_reg == '0) ? '0 : top_reg;
            empty_next     = (sp_reg == '0);
            fill_next      = FILL_W'(sp_reg);
            case (action)
                ACT_PUSH:
                begin
                    if (full)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        sp_next    = sp_plus1;
                        top_next   = push_run;
                        max_next   = push_run;
                        empty_next = 1'b0;
                        fill_next  = FILL_W'(sp_plus1);
                    end
                end
                ACT_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        status_next = STS_EMPTY;
                    end
                    else if (sp_reg == PTR_W'(1))
                    begin
                        sp_next    = '0;
                        max_next   = '0;
                        empty_next = 1'b1;
                        fill_next  = '0;
                    end
                    else
                    begin
                        // Fetch the running maximum of the entry below the top
                        rd_en          = 1'b1;
                        sp_next        = sp_minus1;
                        out_valid_next = 1'b0;
                        state_next     = S_READ;
                    end
                end
                default:
                begin
                    // Query and the unused code leave the stack alone
                end
            endcase
        end
    end

    // Running-maximum RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            run_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= run_mem[rd_addr];
        end
    end

    // Control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCEPT;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        status_reg <= status_next;
        max_reg    <= max_next;
        empty_reg  <= empty_next;
        fill_reg   <= fill_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign max_value  = max_reg;
    assign is_empty   = empty_reg;
    assign fill_count = fill_reg;

    // Checks
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid_reg)
        else $error("pop read did not produce a result");

    a_read_leaves_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (sp_reg != '0))
        else $error("pop read with an empty stack");

    a_sp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PTR_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_empty_max_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (max_reg == '0))
        else $error("empty stack reports a nonzero maximum");

endmodule

`default_nettype wire
